// ===== hw/rtl/hga_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hga_pkg
// Types, codes and helpers shared by the generation-tagged handle allocator.
// ----------------------------------------------------------------------------
package hga_pkg;

	localparam int SLOT_BITS_DEF = 13;
	localparam int REF_BITS_DEF  = 32;
	localparam int HANDLE_W      = 64;
	localparam int COUNT_W       = 32;
	localparam int MAX_WORD      = 32;
	localparam int MAX_WORD_LOG  = 5;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_CHECK   = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_FULL     = 2'd1,
		STS_STALE    = 2'd2,
		STS_RESERVED = 2'd3
	} status_t;

	typedef struct packed {
		op_t                 op;
		logic [HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]  release_count;
		logic                hold_ref;
	} cmd_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle_out;
		status_t             status;
		logic                slot_freed;
	} res_t;

	typedef enum logic [3:0] {
		ST_CLR,
		ST_IDLE,
		ST_S_RD,
		ST_S_CHK,
		ST_E_WRD,
		ST_E_WCAP,
		ST_E_ERD,
		ST_E_ECHK,
		ST_E_WWR,
		ST_L_CHK
	} state_t;

	// lowest set bit of a word; zero when none is set
	function automatic logic [MAX_WORD_LOG-1:0] first_set(input logic [MAX_WORD-1:0] v);
		logic [MAX_WORD_LOG-1:0] r;
		r = '0;
		for (int k = MAX_WORD - 1; k >= 0; k--) begin
			if (v[k]) r = MAX_WORD_LOG'(k);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/hga_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hga_ram
// Single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module hga_ram import hga_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ===== hw/rtl/generation_tagged_handle_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// generation_tagged_handle_allocator_unit
// Next-fit handle allocator over an occupancy bitmap with generation tags.
// ----------------------------------------------------------------------------
//  channel  signals                 handshake
//  command  start, busy, cmd        taken when start & !busy
//  result   done, result            one-cycle strobe, cannot be stalled
//
//  Check and release: one bitmap/entry RAM read; reserved handles need none.
//  Allocate: a read and a check per bitmap word visited, up to NSLOTS/W+1 words;
//  when full, eviction frees every occupied slot with no references, then one
//  more search.
//  Reset and clear-all sweep the bitmap RAM, one word a cycle (NSLOTS/W words,
//  256 at default), with busy high; clear-all strobes its result at the end.
module generation_tagged_handle_allocator_unit import hga_pkg::*; #(
	parameter int SLOT_BITS = SLOT_BITS_DEF,
	parameter int REF_BITS  = REF_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire cmd_t cmd,
	output logic      busy,
	output logic      done,
	output res_t      result
);

	localparam int WLOG = (SLOT_BITS > MAX_WORD_LOG) ? MAX_WORD_LOG : SLOT_BITS - 1;
	localparam int W    = 1 << WLOG;
	localparam int IB   = SLOT_BITS - WLOG;
	localparam int NW   = 1 << IB;
	localparam int GW   = HANDLE_W - SLOT_BITS;
	localparam int EW   = REF_BITS + HANDLE_W;
	localparam int CW   = (REF_BITS > COUNT_W) ? REF_BITS : COUNT_W;

	state_t state_q, state_d;
	cmd_t   cmd_q;
	logic [SLOT_BITS-1:0] lh_q, lg_q;
	logic [GW-1:0]        gen_q;
	logic                 retry_q, clr_resp_q;
	logic [IB:0]          p_q;
	logic [IB-1:0]        ev_w_q, clr_w_q;
	logic [WLOG-1:0]      bit_q;
	logic [W-1:0]         wrd_q;
	logic                 done_q;
	res_t                 res_q;

	logic            bm_we, en_we;
	logic [IB-1:0]   bm_addr;
	logic [W-1:0]    bm_wdata, bm_rdata;
	logic [SLOT_BITS-1:0] en_addr;
	logic [EW-1:0]   en_wdata, en_rdata;

	hga_ram #(.WIDTH(W), .DEPTH(NW)) u_bitmap (
		.clk(clk), .we(bm_we), .addr(bm_addr), .wdata(bm_wdata), .rdata(bm_rdata)
	);
	hga_ram #(.WIDTH(EW), .DEPTH(1 << SLOT_BITS)) u_entry (
		.clk(clk), .we(en_we), .addr(en_addr), .wdata(en_wdata), .rdata(en_rdata)
	);

	// search window
	logic [SLOT_BITS-1:0] st_raw, st_slot, fnd_slot, cs, ev_slot, in_slot;
	logic [IB-1:0]   sw, cur_w;
	logic [WLOG-1:0] sb, fb;
	logic [W-1:0]    free_v;
	logic            any_free, gen_inc, occ, match, kill, last_pass;
	logic [REF_BITS-1:0] en_ref;
	logic [HANDLE_W-1:0] en_h, new_handle;
	logic [GW-1:0]   gen_nx;
	logic [CW-1:0]   cnt_x, ref_x, diff;

	assign st_raw  = lh_q + SLOT_BITS'(1);
	assign st_slot = (st_raw < SLOT_BITS'(2)) ? SLOT_BITS'(2) : st_raw;
	assign sw      = st_slot[SLOT_BITS-1:WLOG];
	assign sb      = st_slot[WLOG-1:0];
	assign cur_w   = sw + p_q[IB-1:0];
	assign last_pass = (p_q == (IB+1)'(NW));

	always_comb begin
		for (int k = 0; k < W; k++) begin
			if (p_q == '0)     free_v[k] = ~bm_rdata[k] & (WLOG'(k) >= sb);
			else if (last_pass) free_v[k] = ~bm_rdata[k] & (WLOG'(k) < sb);
			else                free_v[k] = ~bm_rdata[k];
		end
	end

	assign any_free   = |free_v;
	assign fb         = WLOG'(first_set(MAX_WORD'(free_v)));
	assign fnd_slot   = {cur_w, fb};
	assign gen_inc    = (fnd_slot <= lg_q);
	assign gen_nx     = gen_q + GW'(gen_inc);
	assign new_handle = {gen_nx, fnd_slot};

	assign en_ref = en_rdata[EW-1:HANDLE_W];
	assign en_h   = en_rdata[HANDLE_W-1:0];
	assign cs     = cmd_q.handle[SLOT_BITS-1:0];
	assign in_slot = cmd.handle[SLOT_BITS-1:0];
	assign occ    = bm_rdata[cs[WLOG-1:0]];
	assign match  = occ && (en_h == cmd_q.handle);
	assign cnt_x  = CW'(cmd_q.release_count);
	assign ref_x  = CW'(en_ref);
	assign diff   = ref_x - cnt_x;

	assign ev_slot = {ev_w_q, bit_q};
	assign kill    = wrd_q[bit_q] && (en_ref == '0) && (ev_slot >= SLOT_BITS'(2));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLR:    if (clr_w_q == IB'(NW - 1)) state_d = ST_IDLE;
			ST_IDLE: begin
				if (start) begin
					case (cmd.op)
						OP_ALLOC:   state_d = ST_S_RD;
						OP_RELEASE: if (in_slot >= SLOT_BITS'(2)) state_d = ST_L_CHK;
						OP_CHECK:   if (cmd.handle != HANDLE_W'(1) &&
						                in_slot >= SLOT_BITS'(2)) state_d = ST_L_CHK;
						default:    state_d = ST_CLR;
					endcase
				end
			end
			ST_S_RD:   state_d = ST_S_CHK;
			ST_S_CHK: begin
				if (any_free) state_d = ST_IDLE;
				else if (last_pass) state_d = retry_q ? ST_IDLE : ST_E_WRD;
				else state_d = ST_S_RD;
			end
			ST_E_WRD:  state_d = ST_E_WCAP;
			ST_E_WCAP: state_d = ST_E_ERD;
			ST_E_ERD:  state_d = ST_E_ECHK;
			ST_E_ECHK: state_d = (bit_q == WLOG'(W - 1)) ? ST_E_WWR : ST_E_ERD;
			ST_E_WWR:  state_d = (ev_w_q == IB'(NW - 1)) ? ST_S_RD : ST_E_WRD;
			ST_L_CHK:  state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		bm_we    = 1'b0;
		bm_addr  = cur_w;
		bm_wdata = bm_rdata;
		en_we    = 1'b0;
		en_addr  = cs;
		en_wdata = en_rdata;
		case (state_q)
			ST_CLR: begin
				bm_we    = 1'b1;
				bm_addr  = clr_w_q;
				bm_wdata = (clr_w_q == '0) ? W'(3) : '0;
			end
			ST_IDLE: begin
				bm_addr = in_slot[SLOT_BITS-1:WLOG];
				en_addr = in_slot;
			end
			ST_S_CHK: begin
				if (any_free) begin
					bm_we    = 1'b1;
					bm_wdata = bm_rdata | (W'(1) << fb);
					en_we    = 1'b1;
					en_addr  = fnd_slot;
					en_wdata = {REF_BITS'(cmd_q.hold_ref), new_handle};
				end
			end
			ST_E_WRD:  bm_addr = ev_w_q;
			ST_E_ERD:  en_addr = ev_slot;
			ST_E_WWR: begin
				bm_we    = 1'b1;
				bm_addr  = ev_w_q;
				bm_wdata = wrd_q;
			end
			ST_L_CHK: begin
				bm_addr = cs[SLOT_BITS-1:WLOG];
				if (cmd_q.op == OP_RELEASE && match) begin
					if (cnt_x >= ref_x) begin
						bm_we    = 1'b1;
						bm_wdata = bm_rdata & ~(W'(1) << cs[WLOG-1:0]);
					end else begin
						en_we    = 1'b1;
						en_wdata = {diff[REF_BITS-1:0], en_h};
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			cmd_q      <= '0;
			lh_q       <= SLOT_BITS'(2);
			lg_q       <= SLOT_BITS'(2);
			gen_q      <= '0;
			retry_q    <= 1'b0;
			clr_resp_q <= 1'b0;
			clr_w_q    <= '0;
			p_q        <= '0;
			ev_w_q     <= '0;
			bit_q      <= '0;
			wrd_q      <= '0;
			done_q     <= 1'b0;
			res_q      <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_w_q <= clr_w_q + IB'(1);
					if (clr_w_q == IB'(NW - 1)) begin
						done_q     <= clr_resp_q;
						res_q      <= '0;
						clr_resp_q <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						p_q     <= '0;
						retry_q <= 1'b0;
						res_q   <= '0;
						case (cmd.op)
							OP_ALLOC: ;
							OP_RELEASE: begin
								if (in_slot < SLOT_BITS'(2)) begin
									done_q       <= 1'b1;
									res_q.status <= STS_RESERVED;
								end
							end
							OP_CHECK: begin
								if (cmd.handle == HANDLE_W'(1)) begin
									done_q           <= 1'b1;
									res_q.handle_out <= HANDLE_W'(1);
								end else if (in_slot < SLOT_BITS'(2)) begin
									done_q       <= 1'b1;
									res_q.status <= STS_STALE;
								end
							end
							default: begin
								lh_q       <= SLOT_BITS'(2);
								lg_q       <= SLOT_BITS'(2);
								gen_q      <= '0;
								clr_w_q    <= '0;
								clr_resp_q <= 1'b1;
							end
						endcase
					end
				end
				ST_S_CHK: begin
					if (any_free) begin
						gen_q  <= gen_nx;
						lg_q   <= fnd_slot;
						lh_q   <= fnd_slot;
						done_q <= 1'b1;
						res_q  <= '{handle_out: new_handle, status: STS_OK, slot_freed: 1'b0};
					end else if (last_pass) begin
						ev_w_q <= '0;
						if (retry_q) begin
							done_q <= 1'b1;
							res_q  <= '{handle_out: '0, status: STS_FULL, slot_freed: 1'b0};
						end
					end else begin
						p_q <= p_q + (IB+1)'(1);
					end
				end
				ST_E_WCAP: begin
					wrd_q <= bm_rdata;
					bit_q <= '0;
				end
				ST_E_ECHK: begin
					if (kill) wrd_q[bit_q] <= 1'b0;
					bit_q <= bit_q + WLOG'(1);
				end
				ST_E_WWR: begin
					ev_w_q <= ev_w_q + IB'(1);
					if (ev_w_q == IB'(NW - 1)) begin
						retry_q <= 1'b1;
						p_q     <= '0;
					end
				end
				ST_L_CHK: begin
					done_q <= 1'b1;
					if (!match) begin
						res_q <= '{handle_out: '0, status: STS_STALE, slot_freed: 1'b0};
					end else begin
						res_q <= '{handle_out: cmd_q.handle, status: STS_OK,
						           slot_freed: (cmd_q.op == OP_RELEASE) && (cnt_x >= ref_x)};
					end
				end
				default: ;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

// ===== hw/rtl/hga_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hga_checker
// Port-level checks on result words and the clear sweep.
// ----------------------------------------------------------------------------
module hga_checker import hga_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire cmd_t cmd,
	input wire logic busy,
	input wire logic done,
	input wire res_t result
);

	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.slot_freed |-> result.status == STS_OK)
		else $error("slot freed with failing status");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STS_FULL |-> result.handle_out == '0)
		else $error("full result carries a handle");

	a_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status == STS_RESERVED |->
			result.handle_out == '0 && !result.slot_freed)
		else $error("reserved result carries data");

	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.op == OP_CLEAR |=> busy)
		else $error("clear-all did not start its sweep");

endmodule

bind generation_tagged_handle_allocator_unit hga_checker u_hga_checker (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Handle allocator testbench
// Drives allocate, release, check and clear-all words through the command
// handshake and checks every result against a behavioral copy of the slot
// table, or against a pinned expectation for directed rows. Includes directed
// corner cases and random traffic over live and stale handles.
// ----------------------------------------------------------------------------
module testbench;
	import hga_pkg::*;

	localparam int NSLOTS   = 1 << SLOT_BITS_DEF;
	localparam int GEN_W    = HANDLE_W - SLOT_BITS_DEF;
	localparam int WDOG_MAX = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy, done;
	res_t result;

	// pinned expectation travels with the command word
	logic pin_on = 1'b0;
	res_t pin_res = '0;

	generation_tagged_handle_allocator_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .cmd(cmd),
		.busy(busy), .done(done), .result(result)
	);

	always #6 clk = ~clk;

	// slot table copy
	bit                   occ[NSLOTS];
	logic [REF_BITS_DEF-1:0] refs[NSLOTS];
	logic [HANDLE_W-1:0]  owner[NSLOTS];
	int unsigned          last_handed, last_gen;
	logic [GEN_W-1:0]     gen;

	res_t pending[$];
	logic [HANDLE_W-1:0] live[$];
	int fails = 0;
	int idle_cnt = 0;

	task automatic table_reset();
		for (int s = 0; s < NSLOTS; s++) begin
			occ[s] = (s < 2);
			refs[s] = '0;
			owner[s] = '0;
		end
		last_handed = 2;
		last_gen = 2;
		gen = '0;
		live.delete();
	endtask

	function automatic int unsigned find_slot();
		int unsigned first, s;
		first = last_handed + 1;
		if (first >= NSLOTS || first < 2) first = 2;
		for (int i = 0; i < NSLOTS; i++) begin
			s = (first + i) % NSLOTS;
			if (!occ[s]) begin
				occ[s] = 1'b1;
				last_handed = s;
				return s;
			end
		end
		return 0;
	endfunction

	task automatic model_cmd(input cmd_t c, output res_t r);
		int unsigned s;
		r = '0;
		r.status = STS_OK;
		s = c.handle[SLOT_BITS_DEF-1:0];
		case (c.op)
			OP_ALLOC: begin
				s = find_slot();
				if (s == 0) begin
					// evict idle slots, then search again
					for (int e = 2; e < NSLOTS; e++)
						if (occ[e] && refs[e] == 0) begin
							occ[e] = 1'b0; refs[e] = '0; owner[e] = '0;
						end
					s = find_slot();
				end
				if (s == 0) begin
					r.status = STS_FULL;
				end else begin
					if (s <= last_gen) gen = gen + 1'b1;
					last_gen = s;
					r.handle_out = {gen, SLOT_BITS_DEF'(s)};
					owner[s] = r.handle_out;
					refs[s] = REF_BITS_DEF'(c.hold_ref);
					live.push_back(r.handle_out);
					if (live.size() > 64) void'(live.pop_front());
				end
			end
			OP_RELEASE: begin
				if (s < 2) begin
					r.status = STS_RESERVED;
				end else if (!occ[s] || owner[s] != c.handle) begin
					r.status = STS_STALE;
				end else begin
					r.handle_out = c.handle;
					if (c.release_count >= refs[s]) begin
						occ[s] = 1'b0; refs[s] = '0; owner[s] = '0;
						r.slot_freed = 1'b1;
					end else begin
						refs[s] = refs[s] - c.release_count;
					end
				end
			end
			OP_CHECK: begin
				if (c.handle == 64'd1) r.handle_out = 64'd1;
				else if (s < 2 || !occ[s] || owner[s] != c.handle) r.status = STS_STALE;
				else r.handle_out = c.handle;
			end
			default: table_reset();
		endcase
	endtask

	// accept, predict, compare
	always @(posedge clk) begin
		res_t r, w;
		if (arst_n && start && !busy) begin
			model_cmd(cmd, r);
			pending.push_back(pin_on ? pin_res : r);
		end
		if (arst_n && done) begin
			if (pending.size() == 0) begin
				$error("result word with nothing pending: %h", result);
				fails++;
			end else begin
				w = pending.pop_front();
				if (result.handle_out !== w.handle_out) begin
					$error("handle_out expected %h actual %h", w.handle_out, result.handle_out);
					fails++;
				end
				if (result.status !== w.status) begin
					$error("status expected %0d actual %0d", w.status, result.status);
					fails++;
				end
				if (result.slot_freed !== w.slot_freed) begin
					$error("slot_freed expected %0d actual %0d", w.slot_freed,
						result.slot_freed);
					fails++;
				end
			end
		end
		if ((start && !busy) || done) idle_cnt = 0;
		else idle_cnt++;
		if (idle_cnt >= WDOG_MAX) begin
			$display("Verification failed");
			$finish;
		end
	end

	bit gaps_on = 1'b1;

	task automatic send(input cmd_t c, input logic pin, input res_t pr);
		while (gaps_on && $urandom_range(99) < 7) begin
			@(negedge clk);
			start <= 1'b0;
		end
		@(negedge clk);
		start <= 1'b1;
		cmd <= c;
		pin_on <= pin;
		pin_res <= pr;
		do @(posedge clk); while (busy);
	endtask

	task automatic send_free(input cmd_t c);
		send(c, 1'b0, '0);
	endtask

	function automatic cmd_t mk(input op_t o, input logic [63:0] h,
			input logic [31:0] n, input int t);
		cmd_t c;
		c.op = o; c.handle = h; c.release_count = n; c.hold_ref = t[0];
		return c;
	endfunction

	function automatic res_t rs(input logic [63:0] h, input status_t st, input int f);
		res_t r;
		r.handle_out = h; r.status = st; r.slot_freed = f[0];
		return r;
	endfunction

	typedef struct {
		cmd_t c;
		int   pin;
		res_t r;
	} row_t;

	function automatic cmd_t rand_cmd();
		cmd_t c;
		int k;
		c = '0;
		c.handle = {$urandom, $urandom};
		c.release_count = ($urandom_range(3) == 0) ? $urandom : $urandom_range(2);
		c.hold_ref = 1'($urandom_range(1));
		k = $urandom_range(99);
		if (k < 40) c.op = OP_ALLOC;
		else if (k < 70) c.op = OP_RELEASE;
		else if (k < 99) c.op = OP_CHECK;
		else c.op = OP_CLEAR;
		if (c.op inside {OP_RELEASE, OP_CHECK}) begin
			k = $urandom_range(9);
			if (k < 7 && live.size() > 0) begin
				c.handle = live[$urandom_range(live.size() - 1)];
			end else if (k == 7) begin
				c.handle[SLOT_BITS_DEF-1:0] = SLOT_BITS_DEF'($urandom_range(1));
				if ($urandom_range(1)) c.handle = 64'd1;
			end else if (k == 8 && live.size() > 0) begin
				// stale generation on a real slot
				c.handle = live[$urandom_range(live.size() - 1)]
					^ (64'd1 << $urandom_range(63, SLOT_BITS_DEF));
			end
		end
		return c;
	endfunction

	initial begin
		row_t rows[$];
		int gap_lo, gap_hi;
		table_reset();
		rows = '{
			'{mk(OP_ALLOC, 0, 0, 1), 1, rs(64'd3, STS_OK, 0)},
			'{mk(OP_ALLOC, 0, 0, 0), 1, rs(64'd4, STS_OK, 0)},
			'{mk(OP_CHECK, 64'd1, 0, 0), 1, rs(64'd1, STS_OK, 0)},
			'{mk(OP_CHECK, 64'd0, 0, 0), 1, rs(64'd0, STS_STALE, 0)},
			'{mk(OP_CHECK, 64'h2000, 0, 1), 1, rs(64'd0, STS_STALE, 0)},
			'{mk(OP_RELEASE, 64'd0, 0, 0), 1, rs(64'd0, STS_RESERVED, 0)},
			'{mk(OP_RELEASE, 64'd1, 0, 0), 1, rs(64'd0, STS_RESERVED, 0)},
			'{mk(OP_RELEASE, 64'd3, 0, 0), 1, rs(64'd3, STS_OK, 0)},
			'{mk(OP_RELEASE, 64'd3, 32'hFFFFFFFF, 0), 1, rs(64'd3, STS_OK, 1)},
			'{mk(OP_CHECK, 64'd3, 0, 0), 1, rs(64'd0, STS_STALE, 0)},
			'{mk(OP_RELEASE, 64'd3, 1, 1), 1, rs(64'd0, STS_STALE, 0)},
			'{mk(OP_CHECK, 64'd4, 0, 0), 1, rs(64'd4, STS_OK, 0)},
			'{mk(OP_CHECK, '1, '1, 1), 1, rs(64'd0, STS_STALE, 0)},
			'{mk(OP_RELEASE, '1, '1, 1), 1, rs(64'd0, STS_STALE, 0)},
			'{mk(OP_RELEASE, 64'h2004, 0, 0), 1, rs(64'd0, STS_STALE, 0)},
			'{mk(OP_ALLOC, 0, 0, 1), 0, '0},
			'{mk(OP_RELEASE, 64'd4, 0, 0), 1, rs(64'd4, STS_OK, 1)},
			'{mk(OP_CLEAR, '1, '1, 1), 1, rs(64'd0, STS_OK, 0)},
			'{mk(OP_ALLOC, 0, 0, 0), 1, rs(64'd3, STS_OK, 0)},
			'{mk(OP_CHECK, 64'd3, 0, 0), 1, rs(64'd3, STS_OK, 0)},
			'{mk(OP_CLEAR, 0, 0, 0), 1, rs(64'd0, STS_OK, 0)}
		};
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		foreach (rows[i]) send(rows[i].c, rows[i].pin != 0, rows[i].r);
		gap_lo = $urandom_range(300, 600);
		gap_hi = gap_lo + $urandom_range(300, 500);
		for (int i = 0; i < 1580; i++) begin
			gaps_on = !(i >= gap_lo && i < gap_hi);
			send_free(rand_cmd());
		end
		gaps_on = 1'b1;
		@(negedge clk);
		start <= 1'b0;
		pin_on <= 1'b0;
		wait (pending.size() == 0);
		repeat (400) @(posedge clk);
		if (fails == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

endmodule
